### hdl/kts_pkg.sv
// ============================================================================
// kts_pkg: shared types and constants for the keyed table block
// Opcodes, status codes, controller states and command/status structs.
// ============================================================================
package kts_pkg;

    localparam int CAPACITY_DEF   = 16;
    localparam int NAME_BYTES_DEF = 8;
    localparam int TYPE_BYTES_DEF = 8;

    localparam logic [2:0] OP_INSERT  = 3'd0;
    localparam logic [2:0] OP_REMOVE  = 3'd1;
    localparam logic [2:0] OP_DUMP    = 3'd2;
    localparam logic [2:0] OP_LSEARCH = 3'd3;
    localparam logic [2:0] OP_SORT    = 3'd4;
    localparam logic [2:0] OP_BSEARCH = 3'd5;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_EMPTY    = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_FEW      = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,     // wait for a command
        S_DECODE,   // command latched, pick a path
        S_RD,       // memory read issued at index
        S_LS_CHK,   // linear search / remove scan compare
        S_SHIFT_RD, // read entry j+1
        S_SHIFT_WR, // write it to j
        S_SO_RDB,   // sort: read j+1 after j
        S_SO_CMP,   // sort: compare pair, maybe swap
        S_SO_WR2,   // sort: second half of swap
        S_BS_CHK,   // binary search compare
        S_DUMP,     // present dumped entry
        S_RESP      // hold result until taken
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic       latch_in;   // capture input item
        logic       rd_a;       // read port a at addr_a
        logic       rd_b;       // read port b at addr_b
        logic       wr;         // write
        logic [1:0] wr_src;     // 0 input item, 1 port b data, 2 port a data
        logic       res_entry;  // result carries port a data
        logic       res_load;   // load result register
        logic [2:0] res_status;
        logic       res_last;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic eq_a;   // key == entry at port a
        logic lt_a;   // key <  entry at port a
        logic gt_ab;  // entry a > entry b
    } t_sts;

    // clear bytes after the first NUL and beyond nbytes
    function automatic logic [63:0] norm_text(input logic [63:0] v, input int nbytes);
        logic [63:0] r;
        logic        dead;
        r    = v;
        dead = 1'b0;
        for (int k = 0; k < 8; k++) begin
            if (k >= nbytes || r[63-8*k -: 8] == 8'h00) dead = 1'b1;
            if (dead) r[63-8*k -: 8] = 8'h00;
        end
        return r;
    endfunction

endpackage

### hdl/keyed_table_sort_search.sv
// ============================================================================
// keyed_table_sort_search: table with insert, remove, dump, searches, sort
// Controller sequences a register-file datapath; one command at a time.
// ============================================================================
//  channel | dir | fields (tdata low bit up)
//  s_axis  | in  | opcode[2:0] key_name[66:3] type_text[130:67] quantity_in[162:131]
//  m_axis  | out | status[2:0] entry_index[6:3] entry_name[70:7]
//          |     | entry_type[134:71] entry_quantity[166:135]; tlast = last
//
//  One command is taken at a time; s_axis_tready is high only when idle.
//  Insert and errors answer from decode. Scan/remove compare one entry at a
//  time, then shift each later entry down one slot. Sort compares n(n-1)/2
//  pairs. Binary search probes the midpoint. Dump gives one entry per result.
//  Results sit in an output register until m_axis_tready; reset clears count
//  and state but not the table, whose contents are undefined until written.
module keyed_table_sort_search #(
    parameter int CAPACITY   = kts_pkg::CAPACITY_DEF,
    parameter int NAME_BYTES = kts_pkg::NAME_BYTES_DEF,
    parameter int TYPE_BYTES = kts_pkg::TYPE_BYTES_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [167:0] s_axis_tdata,  // opcode, key_name, type_text, quantity_in
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [167:0] m_axis_tdata,  // status, entry_index, entry_name, type, qty
    output logic         m_axis_tlast
);
    import kts_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    t_cmd w_cmd;
    t_sts w_sts;
    logic [AW-1:0] w_aa, w_ab, w_aw, w_ri;
    logic [CW-1:0] w_cnt;
    logic [2:0] w_op, w_status;
    logic [3:0] w_index;
    logic [63:0] w_name, w_type;
    logic [31:0] w_qty;

    kts_ctrl #(.CAPACITY(CAPACITY), .AW(AW), .CW(CW)) u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_valid(s_axis_tvalid), .o_in_ready(s_axis_tready),
        .o_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_op(w_op), .i_sts(w_sts), .o_cmd(w_cmd),
        .o_addr_a(w_aa), .o_addr_b(w_ab), .o_addr_w(w_aw), .o_res_idx(w_ri),
        .o_count(w_cnt)
    );

    kts_datapath #(.CAPACITY(CAPACITY), .NAME_BYTES(NAME_BYTES),
                   .TYPE_BYTES(TYPE_BYTES), .AW(AW)) u_dp (
        .i_clk, .i_cmd(w_cmd),
        .i_addr_a(w_aa), .i_addr_b(w_ab), .i_addr_w(w_aw), .i_res_idx(w_ri),
        .i_key(s_axis_tdata[66:3]), .i_type(s_axis_tdata[130:67]),
        .i_qty(s_axis_tdata[162:131]),
        .o_op(w_op), .o_sts(w_sts), .o_status(w_status), .o_index(w_index),
        .o_name(w_name), .o_type(w_type), .o_qty(w_qty), .o_last(m_axis_tlast),
        .i_op(s_axis_tdata[2:0])
    );

    assign m_axis_tdata = {1'b0, w_qty, w_type, w_name, w_index, w_status};

`ifndef NO_ASSERTIONS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cnt <= CW'(CAPACITY)) else $error("count beyond capacity");
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid)) else $error("ready while result pending");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped");
`endif

endmodule

### hdl/kts_datapath.sv
// ============================================================================
// kts_datapath: entry memories, key compare and result register
// Three parallel stores sharing two read ports and one write port.
// ============================================================================
module kts_datapath #(
    parameter int CAPACITY   = kts_pkg::CAPACITY_DEF,
    parameter int NAME_BYTES = kts_pkg::NAME_BYTES_DEF,
    parameter int TYPE_BYTES = kts_pkg::TYPE_BYTES_DEF,
    parameter int AW         = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
    input  logic          i_clk,
    input  kts_pkg::t_cmd i_cmd,
    input  logic [AW-1:0] i_addr_a,
    input  logic [AW-1:0] i_addr_b,
    input  logic [AW-1:0] i_addr_w,
    input  logic [AW-1:0] i_res_idx,
    input  logic [63:0]   i_key,
    input  logic [63:0]   i_type,
    input  logic [31:0]   i_qty,
    output logic [2:0]    o_op,
    output kts_pkg::t_sts o_sts,
    output logic [2:0]    o_status,
    output logic [3:0]    o_index,
    output logic [63:0]   o_name,
    output logic [63:0]   o_type,
    output logic [31:0]   o_qty,
    output logic          o_last,
    input  logic [2:0]    i_op
);
    import kts_pkg::*;

    logic [63:0] r_name_mem [CAPACITY];
    logic [63:0] r_type_mem [CAPACITY];
    logic [31:0] r_qty_mem  [CAPACITY];

    logic [63:0] r_key, r_ty;
    logic [31:0] r_q;
    logic [2:0]  r_op;
    logic [63:0] r_an, r_at, r_bn, r_bt;
    logic [31:0] r_aq, r_bq;
    logic [2:0]  r_status;
    logic [3:0]  r_index;
    logic [63:0] r_rn, r_rt;
    logic [31:0] r_rq;
    logic        r_last;

    logic [63:0] w_n, w_t;
    logic [31:0] w_q;

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_op  <= i_op;
            r_key <= norm_text(i_key, NAME_BYTES);
            r_ty  <= norm_text(i_type, TYPE_BYTES);
            r_q   <= i_qty;
        end
        if (i_cmd.rd_a) begin
            r_an <= r_name_mem[i_addr_a];
            r_at <= r_type_mem[i_addr_a];
            r_aq <= r_qty_mem[i_addr_a];
        end
        if (i_cmd.rd_b) begin
            r_bn <= r_name_mem[i_addr_b];
            r_bt <= r_type_mem[i_addr_b];
            r_bq <= r_qty_mem[i_addr_b];
        end
        if (i_cmd.wr) begin
            r_name_mem[i_addr_w] <= w_n;
            r_type_mem[i_addr_w] <= w_t;
            r_qty_mem[i_addr_w]  <= w_q;
        end
        if (i_cmd.res_load) begin
            r_status <= i_cmd.res_status;
            r_last   <= i_cmd.res_last;
            r_index  <= i_cmd.res_entry ? 4'(i_res_idx) : 4'd0;
            r_rn     <= i_cmd.res_entry ? r_an : 64'd0;
            r_rt     <= i_cmd.res_entry ? r_at : 64'd0;
            r_rq     <= i_cmd.res_entry ? r_aq : 32'd0;
        end
    end

    always_comb begin
        case (i_cmd.wr_src)
            2'd1: begin w_n = r_bn; w_t = r_bt; w_q = r_bq; end
            2'd2: begin w_n = r_an; w_t = r_at; w_q = r_aq; end
            default: begin w_n = r_key; w_t = r_ty; w_q = r_q; end
        endcase
    end

    assign o_sts.eq_a  = (r_key == r_an);
    assign o_sts.lt_a  = (r_key < r_an);
    assign o_sts.gt_ab = (r_an > r_bn);
    assign o_op     = r_op;
    assign o_status = r_status;
    assign o_index  = r_index;
    assign o_name   = r_rn;
    assign o_type   = r_rt;
    assign o_qty    = r_rq;
    assign o_last   = r_last;

endmodule

### hdl/kts_ctrl.sv
// ============================================================================
// kts_ctrl: command sequencer
// Walks table indices for scan, shift, bubble sort and binary search.
// ============================================================================
module kts_ctrl #(
    parameter int CAPACITY = kts_pkg::CAPACITY_DEF,
    parameter int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    parameter int CW       = $clog2(CAPACITY + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  logic [2:0]    i_op,
    input  kts_pkg::t_sts i_sts,
    output kts_pkg::t_cmd o_cmd,
    output logic [AW-1:0] o_addr_a,
    output logic [AW-1:0] o_addr_b,
    output logic [AW-1:0] o_addr_w,
    output logic [AW-1:0] o_res_idx,
    output logic [CW-1:0] o_count
);
    import kts_pkg::*;

    t_state r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;   // entry count
    logic [CW-1:0] r_i, n_i;       // scan / pass index
    logic [CW-1:0] r_j, n_j;       // inner index
    logic [CW:0]   r_lo, n_lo, r_hi, n_hi; // signed-free: hi kept +1
    logic          r_more, n_more; // dump continues after result taken

    localparam logic [CW-1:0] CAP = CW'(CAPACITY);
    logic [CW:0] w_mid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_more  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_more  <= n_more;
        end
        r_i  <= n_i;
        r_j  <= n_j;
        r_lo <= n_lo;
        r_hi <= n_hi;
    end

    // hi is stored as hi+1, so the live range is lo < hi
    assign w_mid = (r_lo + r_hi - 1'b1) >> 1;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_i     = r_i;
        n_j     = r_j;
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_more  = r_more;
        o_cmd   = '0;
        o_addr_a  = AW'(r_i);
        o_addr_b  = AW'(r_j);
        o_addr_w  = AW'(r_j);
        o_res_idx = AW'(r_i);
        o_in_ready  = (r_state == S_IDLE);
        o_out_valid = (r_state == S_RESP);

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch_in = 1'b1;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_i = '0;
                n_j = '0;
                o_cmd.res_load = 1'b1;
                o_cmd.res_last = 1'b1;
                o_cmd.res_status = ST_OK;
                n_state = S_RESP;
                n_more  = 1'b0;
                case (i_op)
                    OP_INSERT: begin
                        if (r_cnt >= CAP) o_cmd.res_status = ST_FULL;
                        else begin
                            o_cmd.wr = 1'b1;
                            o_addr_w = AW'(r_cnt);
                            n_cnt = r_cnt + 1'b1;
                        end
                    end
                    OP_SORT: begin
                        if (r_cnt < CW'(2)) o_cmd.res_status = ST_FEW;
                        else begin
                            o_cmd.res_load = 1'b0;
                            o_addr_a = '0; o_addr_b = AW'(1);
                            o_cmd.rd_a = 1'b1;
                            n_state = S_SO_RDB;
                        end
                    end
                    OP_REMOVE, OP_DUMP, OP_LSEARCH, OP_BSEARCH: begin
                        if (r_cnt == '0) o_cmd.res_status = ST_EMPTY;
                        else begin
                            o_cmd.res_load = 1'b0;
                            n_lo = '0;
                            n_hi = {1'b0, r_cnt};
                            n_state = S_RD;
                        end
                    end
                    default: begin
                        o_cmd.res_load = 1'b0;
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_RD: begin
                o_cmd.rd_a = 1'b1;
                if (i_op == OP_BSEARCH) begin
                    o_addr_a = AW'(w_mid);
                    n_i = CW'(w_mid);
                    n_state = S_BS_CHK;
                end else if (i_op == OP_DUMP) n_state = S_DUMP;
                else n_state = S_LS_CHK;
            end
            S_DUMP: begin
                o_cmd.res_load  = 1'b1;
                o_cmd.res_entry = 1'b1;
                o_cmd.res_last  = (r_i + 1'b1 == r_cnt);
                n_more  = (r_i + 1'b1 != r_cnt);
                n_state = S_RESP;
            end
            S_LS_CHK: begin
                if (i_sts.eq_a) begin
                    if (i_op == OP_LSEARCH) begin
                        o_cmd.res_load = 1'b1; o_cmd.res_entry = 1'b1;
                        o_cmd.res_last = 1'b1; n_state = S_RESP;
                    end else begin
                        n_j = r_i;
                        n_state = S_SHIFT_RD;
                    end
                end else if (r_i + 1'b1 == r_cnt) begin
                    o_cmd.res_load = 1'b1; o_cmd.res_last = 1'b1;
                    o_cmd.res_status = ST_NOTFOUND; n_state = S_RESP;
                end else begin
                    n_i = r_i + 1'b1;
                    n_state = S_RD;
                end
            end
            S_SHIFT_RD: begin
                if (r_j + 1'b1 >= r_cnt) begin
                    n_cnt = r_cnt - 1'b1;
                    o_cmd.res_load = 1'b1; o_cmd.res_last = 1'b1;
                    n_state = S_RESP;
                end else begin
                    o_cmd.rd_b = 1'b1;
                    o_addr_b = AW'(r_j + 1'b1);
                    n_state = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR: begin
                o_cmd.wr = 1'b1; o_cmd.wr_src = 2'd1;
                n_j = r_j + 1'b1;
                n_state = S_SHIFT_RD;
            end
            S_SO_RDB: begin
                o_cmd.rd_b = 1'b1;
                o_addr_b = AW'(r_j + 1'b1);
                n_state = S_SO_CMP;
            end
            S_SO_CMP: begin
                // a holds [j], b holds [j+1]
                if (i_sts.gt_ab) begin
                    o_cmd.wr = 1'b1; o_cmd.wr_src = 2'd1;
                    n_state = S_SO_WR2;
                end else n_state = S_SO_WR2;
            end
            S_SO_WR2: begin
                // after a swap the larger (a) goes to j+1; otherwise nothing is written
                if (i_sts.gt_ab) begin
                    o_cmd.wr = 1'b1; o_cmd.wr_src = 2'd2;
                    o_addr_w = AW'(r_j + 1'b1);
                end
                if (r_j + CW'(2) + r_i < r_cnt) begin
                    n_j = r_j + 1'b1;
                    // after a swap port a already holds the new [j+1]
                    o_cmd.rd_a = !i_sts.gt_ab;
                    o_addr_a = AW'(r_j + 1'b1);
                    n_state = S_SO_RDB;
                end else if (r_i + CW'(2) < r_cnt) begin
                    n_i = r_i + 1'b1; n_j = '0;
                    o_cmd.rd_a = 1'b1; o_addr_a = '0;
                    n_state = S_SO_RDB;
                end else begin
                    o_cmd.res_load = 1'b1; o_cmd.res_last = 1'b1;
                    n_state = S_RESP;
                end
            end
            S_BS_CHK: begin
                if (i_sts.eq_a) begin
                    o_cmd.res_load = 1'b1; o_cmd.res_entry = 1'b1;
                    o_cmd.res_last = 1'b1; n_state = S_RESP;
                end else begin
                    if (i_sts.lt_a) n_hi = {1'b0, r_i};
                    else n_lo = {1'b0, r_i} + 1'b1;
                    if ((i_sts.lt_a ? r_lo : ({1'b0, r_i} + 1'b1))
                        >= (i_sts.lt_a ? {1'b0, r_i} : r_hi)) begin
                        o_cmd.res_load = 1'b1; o_cmd.res_last = 1'b1;
                        o_cmd.res_status = ST_NOTFOUND; n_state = S_RESP;
                    end else n_state = S_RD;
                end
            end
            S_RESP: begin
                if (i_out_ready) begin
                    if (r_more) begin
                        n_i = r_i + 1'b1;
                        n_state = S_RD;
                    end else n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_count = r_cnt;

endmodule
